// File: rtl/conv2d_bias_relu_top_assert.svh
// Assertion macros shared by the conv2d_bias_relu RTL.
// Included by files that assert; depends on nothing else.
`ifndef CONV2D_BIAS_RELU_TOP_ASSERT_SVH
`define CONV2D_BIAS_RELU_TOP_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset
`define CBR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset
`define CBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cbr_pkg.sv
// Package for conv2d_bias_relu: sizes, codes, command/status structs.
// No dependencies.
`default_nettype none
package cbr_pkg;

    localparam int MAX_WIDTH    = 64;
    localparam int MAX_HEIGHT   = 1024;
    localparam int MAX_KERNELS  = 8;
    localparam int MAX_KSIZE    = 5;
    localparam int WIN_N        = MAX_KSIZE * MAX_KSIZE;
    localparam int WSTORE_DEPTH = MAX_KERNELS * WIN_N;
    localparam int LSTORE_DEPTH = MAX_KSIZE * MAX_WIDTH;
    localparam int COL_W        = 6;
    localparam int ROW_W        = 10;
    localparam int KIDX_W       = 3;
    localparam int KS_W         = 3;
    localparam int WIN_W        = 5;
    localparam int WADDR_W      = 8;
    localparam int LADDR_W      = 9;
    localparam int ACC_W        = 40;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 11;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_WEIGHT = 2'd1,
        KIND_BIAS   = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_WIDTH  = 3'd2,
        CFG_KERNEL_HEIGHT = 3'd3,
        CFG_KERNEL_COUNT  = 3'd4,
        CFG_BIAS_ENABLE   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic              in_ready;
        logic              fill_issue;
        logic              mac_issue;
        logic              load;
        logic              first_tap;
        logic              last_tap;
        logic              last_k;
        logic [KIDX_W-1:0] k;
        logic [KS_W-1:0]   ky;
        logic [KS_W-1:0]   kx;
    } t_cmd;

    typedef struct packed {
        logic            win_start;
        logic            acc_done;
        logic            out_free;
        logic [KS_W-1:0] kw;
        logic [KS_W-1:0] kh;
        logic [3:0]      kc;
    } t_stat;

    // Saturate to signed Q3.12
    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/cbr_if.sv
// Handshake channels of conv2d_bias_relu: pixel/weight input, result, config.
// Depends on cbr_pkg.
`default_nettype none
interface cbr_in_if import cbr_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic               frame_start;
    logic [7:0]         slot;
    logic signed [31:0] sample;
    modport source (output valid, kind, frame_start, slot, sample, input ready);
    modport sink (input valid, kind, frame_start, slot, sample, output ready);
endinterface

interface cbr_out_if import cbr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIDX_W-1:0] kernel_index;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic [31:0]       activation;
    logic              last;
    modport source (output valid, kernel_index, out_row, out_col, activation, last,
                    input ready);
    modport sink (input valid, kernel_index, out_row, out_col, activation, last,
                  output ready);
endinterface

interface cbr_cfg_if import cbr_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/cbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cbr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/cbr_ctrl.sv
// Sequencer of conv2d_bias_relu: window fill, per-kernel MAC taps, result load.
// Depends on cbr_pkg.
`default_nettype none
module cbr_ctrl import cbr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    typedef enum logic [1:0] {ST_IDLE, ST_FILL, ST_MAC, ST_WAIT} t_state;

    t_state            r_state;
    logic [KIDX_W-1:0] r_k;
    logic [KS_W-1:0]   r_ky;
    logic [KS_W-1:0]   r_kx;
    logic              row_end;
    logic              last_tap;
    logic              last_k;
    logic              load;

    assign row_end  = (r_kx == i_stat.kw - 3'd1);
    assign last_tap = row_end && (r_ky == i_stat.kh - 3'd1);
    assign last_k   = ({1'b0, r_k} == i_stat.kc - 4'd1);
    assign load     = (r_state == ST_WAIT) && i_stat.acc_done && i_stat.out_free;

    // State and tap counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_ky    <= '0;
            r_kx    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_stat.win_start) begin
                        r_state <= ST_FILL;
                        r_ky    <= '0;
                        r_kx    <= '0;
                    end
                end
                ST_FILL, ST_MAC: begin
                    if (last_tap) begin
                        r_ky    <= '0;
                        r_kx    <= '0;
                        if (r_state == ST_FILL) begin
                            r_k     <= '0;
                            r_state <= ST_MAC;
                        end else begin
                            r_state <= ST_WAIT;
                        end
                    end else if (row_end) begin
                        r_kx <= '0;
                        r_ky <= r_ky + 3'd1;
                    end else begin
                        r_kx <= r_kx + 3'd1;
                    end
                end
                ST_WAIT: begin
                    if (load) begin
                        if (last_k) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= ST_MAC;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Decode commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.in_ready   = (r_state == ST_IDLE);
        o_cmd.fill_issue = (r_state == ST_FILL);
        o_cmd.mac_issue  = (r_state == ST_MAC);
        o_cmd.load       = load;
        o_cmd.first_tap  = (r_kx == '0) && (r_ky == '0);
        o_cmd.last_tap   = last_tap;
        o_cmd.last_k     = last_k;
        o_cmd.k          = r_k;
        o_cmd.ky         = r_ky;
        o_cmd.kx         = r_kx;
    end
endmodule
`default_nettype wire

// File: rtl/cbr_datapath.sv
// Datapath of conv2d_bias_relu: config, position, stores, window, MAC, output.
// Depends on cbr_pkg, cbr_if, cbr_ram and the assertion macro header.
`default_nettype none
`include "conv2d_bias_relu_top_assert.svh"
module cbr_datapath import cbr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cbr_in_if.sink    i_pix,
    cbr_out_if.source o_res,
    cbr_cfg_if.sink   i_cfg,
    input  wire t_cmd i_cmd,
    output t_stat     o_stat
);
    // Configuration registers
    logic [6:0]  r_img_w;
    logic [10:0] r_img_h;
    logic [2:0]  r_ker_w;
    logic [2:0]  r_ker_h;
    logic [3:0]  r_ker_n;
    logic        r_bias_en;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w   <= 7'd64;
            r_img_h   <= 11'd64;
            r_ker_w   <= 3'd3;
            r_ker_h   <= 3'd3;
            r_ker_n   <= 4'd8;
            r_bias_en <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_IMAGE_WIDTH:   r_img_w   <= i_cfg.data[6:0];
                CFG_IMAGE_HEIGHT:  r_img_h   <= i_cfg.data;
                CFG_KERNEL_WIDTH:  r_ker_w   <= i_cfg.data[2:0];
                CFG_KERNEL_HEIGHT: r_ker_h   <= i_cfg.data[2:0];
                CFG_KERNEL_COUNT:  r_ker_n   <= i_cfg.data[3:0];
                CFG_BIAS_ENABLE:   r_bias_en <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Clamp to legal ranges: zero counts as one
    logic [6:0]  w;
    logic [10:0] h;
    logic [2:0]  kw;
    logic [2:0]  kh;
    logic [3:0]  kc;

    assign w  = (r_img_w == '0) ? 7'd1 :
                (r_img_w > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : r_img_w;
    assign h  = (r_img_h == '0) ? 11'd1 :
                (r_img_h > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : r_img_h;
    assign kw = (r_ker_w == '0) ? 3'd1 : (r_ker_w > 3'(MAX_KSIZE)) ? 3'(MAX_KSIZE) : r_ker_w;
    assign kh = (r_ker_h == '0) ? 3'd1 : (r_ker_h > 3'(MAX_KSIZE)) ? 3'(MAX_KSIZE) : r_ker_h;
    assign kc = (r_ker_n == '0) ? 4'd1 :
                (r_ker_n > 4'(MAX_KERNELS)) ? 4'(MAX_KERNELS) : r_ker_n;

    // Request decode
    logic               acc_any;
    logic               pix_acc;
    logic signed [15:0] sample16;

    assign i_pix.ready = i_cmd.in_ready;
    assign acc_any     = i_pix.valid && i_pix.ready;
    assign pix_acc     = acc_any && (i_pix.kind == KIND_PIXEL);
    assign sample16    = sat16(i_pix.sample);

    // Raster position; the row modulo the line ring travels with it
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [2:0]       r_rmod;
    logic [COL_W-1:0] c0, c;
    logic [ROW_W-1:0] r0, r;
    logic [2:0]       m0, m, m_inc, mm, m_nxt;
    logic [10:0]      rr, rn;
    logic [6:0]       cn;
    logic             complete;
    logic [3:0]       omod_t;

    always_comb begin
        c0 = i_pix.frame_start ? '0 : r_col;
        r0 = i_pix.frame_start ? '0 : r_row;
        m0 = i_pix.frame_start ? '0 : r_rmod;
        m_inc = (m0 == 3'd4) ? 3'd0 : m0 + 3'd1;
        if ({1'b0, c0} >= w) begin
            c  = '0;
            rr = {1'b0, r0} + 11'd1;
            mm = m_inc;
        end else begin
            c  = c0;
            rr = {1'b0, r0};
            mm = m0;
        end
        if (rr >= h) begin
            r = '0;
            m = '0;
        end else begin
            r = rr[ROW_W-1:0];
            m = mm;
        end
        complete = (({1'b0, r} + 11'd1) >= {8'd0, kh}) && (({1'b0, c} + 7'd1) >= {4'd0, kw});
        omod_t = {1'b0, m} + 4'd6 - {1'b0, kh};
        if (omod_t >= 4'd5) begin
            omod_t = omod_t - 4'd5;
        end
        m_nxt = (m == 3'd4) ? 3'd0 : m + 3'd1;
        cn = {1'b0, c} + 7'd1;
        rn = {1'b0, r} + 11'd1;
    end

    // Hold window origin of the current pixel
    logic [ROW_W-1:0] r_orow;
    logic [COL_W-1:0] r_ocol;
    logic [2:0]       r_omod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_rmod <= '0;
        end else if (pix_acc) begin
            if (cn >= w) begin
                r_col <= '0;
                if (rn >= h) begin
                    r_row  <= '0;
                    r_rmod <= '0;
                end else begin
                    r_row  <= rn[ROW_W-1:0];
                    r_rmod <= m_nxt;
                end
            end else begin
                r_col  <= cn[COL_W-1:0];
                r_row  <= r;
                r_rmod <= m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_orow <= r - ROW_W'(kh - 3'd1);
            r_ocol <= c - COL_W'(kw - 3'd1);
            r_omod <= omod_t[2:0];
        end
    end

    // Line store
    logic [3:0]         lrow_t;
    logic [LADDR_W-1:0] l_raddr;
    logic [15:0]        l_rdata;

    assign lrow_t  = {1'b0, r_omod} + {1'b0, i_cmd.ky};
    assign l_raddr = {(lrow_t >= 4'd5) ? 3'(lrow_t - 4'd5) : lrow_t[2:0],
                      r_ocol + COL_W'(i_cmd.kx)};

    cbr_ram #(.WIDTH(16), .DEPTH(LSTORE_DEPTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (pix_acc),
        .i_waddr ({m, c}),
        .i_wdata (sample16),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    // Weight store
    logic               w_we;
    logic [WADDR_W-1:0] w_raddr;
    logic [15:0]        w_rdata;

    assign w_we    = acc_any && (i_pix.kind == KIND_WEIGHT) &&
                     (i_pix.slot < 8'(WSTORE_DEPTH));
    assign w_raddr = WADDR_W'({5'd0, i_cmd.k} * 8'(WIN_N)) +
                     WADDR_W'({5'd0, i_cmd.ky} * 8'(MAX_KSIZE)) + WADDR_W'(i_cmd.kx);

    cbr_ram #(.WIDTH(16), .DEPTH(WSTORE_DEPTH)) u_weight (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_pix.slot),
        .i_wdata (sample16),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Bias store
    logic signed [31:0] r_bias [MAX_KERNELS];

    always_ff @(posedge i_clk) begin
        if (acc_any && (i_pix.kind == KIND_BIAS) && (i_pix.slot < 8'(MAX_KERNELS))) begin
            r_bias[i_pix.slot[KIDX_W-1:0]] <= i_pix.sample;
        end
    end

    // Window fill: store line data in the cycle after the read
    logic [WIN_W-1:0]   tap_idx;
    logic               r_f1_v;
    logic [WIN_W-1:0]   r_f1_idx;
    logic signed [15:0] r_win [WIN_N];

    assign tap_idx = WIN_W'({2'd0, i_cmd.ky} * 5'(MAX_KSIZE)) + WIN_W'(i_cmd.kx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else begin
            r_f1_v <= i_cmd.fill_issue;
        end
        r_f1_idx <= tap_idx;
        if (r_f1_v) begin
            r_win[r_f1_idx] <= l_rdata;
        end
    end

    // MAC pipeline: weight read, product, accumulate
    logic                    r_s1_v, r_s1_first, r_s1_last;
    logic [WIN_W-1:0]        r_s1_idx;
    logic                    r_s2_v, r_s2_first, r_s2_last;
    logic signed [31:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_acc_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_acc_done <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.mac_issue;
            r_s2_v <= r_s1_v;
            if (i_cmd.load) begin
                r_acc_done <= 1'b0;
            end else if (r_s2_v && r_s2_last) begin
                r_acc_done <= 1'b1;
            end
        end
        r_s1_idx   <= tap_idx;
        r_s1_first <= i_cmd.first_tap;
        r_s1_last  <= i_cmd.last_tap;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_prod     <= r_win[r_s1_idx] * $signed(w_rdata);
        if (r_s2_v) begin
            r_acc <= r_s2_first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    // Bias, ReLU and saturation into the output register
    logic signed [ACC_W-1:0] sum;
    logic [31:0]             act;
    logic                    r_out_v;
    logic                    out_free;

    assign sum = r_acc + (r_bias_en ? ACC_W'(r_bias[i_cmd.k]) : '0);
    assign act = sum[ACC_W-1] ? 32'd0 :
                 (sum[ACC_W-2:32] != '0) ? 32'hFFFF_FFFF : sum[31:0];
    assign out_free = !r_out_v || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_v <= 1'b1;
        end else if (o_res.ready) begin
            r_out_v <= 1'b0;
        end
        if (i_cmd.load) begin
            o_res.kernel_index <= i_cmd.k;
            o_res.out_row      <= r_orow;
            o_res.out_col      <= r_ocol;
            o_res.activation   <= act;
            o_res.last         <= i_cmd.last_k;
        end
    end

    assign o_res.valid = r_out_v;

    // Status to the sequencer
    always_comb begin
        o_stat           = '0;
        o_stat.win_start = pix_acc && complete;
        o_stat.acc_done  = r_acc_done;
        o_stat.out_free  = out_free;
        o_stat.kw        = kw;
        o_stat.kh        = kh;
        o_stat.kc        = kc;
    end

    `CBR_ASSERT_SAME(a_load_after_acc, i_clk, i_rst_n, i_cmd.load, r_acc_done && out_free,
        "result loaded before accumulation finished or while output blocked")
    `CBR_ASSERT_NEXT(a_acc_done_holds, i_clk, i_rst_n, r_acc_done && !i_cmd.load, r_acc_done,
        "finished sum dropped before load")
    `CBR_ASSERT_SAME(a_no_mac_over_done, i_clk, i_rst_n, r_s2_v, !r_acc_done,
        "new taps accumulated over an unloaded sum")
endmodule
`default_nettype wire

// File: rtl/conv2d_bias_relu_top.sv
// conv2d_bias_relu: single-channel valid 2D convolution, several kernels,
// optional per-kernel bias, ReLU and saturation to unsigned Q8.24.
// Channels: i_pix takes pixels (kind 0), weights (kind 1) and biases (kind 2);
// o_res delivers one result per kernel for each pixel that closes a window,
// kernel 0 first, last set on the final kernel. i_cfg writes the six registers
// and is always ready; write it only while the block is idle.
// Weight, bias and pixels that close no window are accepted while the sequencer stays idle.
// For a pixel that closes a window, the window is read from the line RAM
// one tap a cycle, then each kernel runs one MAC tap a cycle through a
// three-stage pipeline behind the weight RAM port, and its result is loaded
// into the output register.
// A stalled receiver holds the result register; the sequencer waits before
// loading the next kernel's result, and no new request is taken until the
// last kernel of the pixel is loaded. Reset (synchronous, active low) restores
// the register defaults and position (0,0); stores are undefined until written.
`default_nettype none
module conv2d_bias_relu_top import cbr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cbr_in_if.sink    i_pix,
    cbr_out_if.source o_res,
    cbr_cfg_if.sink   i_cfg
);
    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    cbr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Datapath
    cbr_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_res   (o_res),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for conv2d_bias_relu_top: directed table, then random phases.
// Predicts every result in the bench itself and checks it field by field.
// Depends on cbr_pkg, the channel interfaces in rtl/cbr_if.sv and the top level.
`default_nettype none
module tb_top;
    import cbr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HOLD_CYCLES = 400;
    localparam int          SETTLE      = 300;
    localparam int          MAX_GAP     = 13;
    localparam longint      CYCLE_LIMIT = 1000000;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         kind;
        logic               frame_start;
        logic [7:0]         slot;
        logic signed [31:0] sample;
        bit                 typed;
        logic [31:0]        typed_act;
    } t_req;

    typedef struct {
        logic [KIDX_W-1:0] kidx;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [31:0]       act;
        logic              last;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cbr_in_if  pix_if();
    cbr_out_if res_if();
    cbr_cfg_if cfg_if();

    conv2d_bias_relu_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #6 i_clk = ~i_clk;

    // Mirror of the block's state
    logic signed [15:0] line_mem [LSTORE_DEPTH];
    logic signed [15:0] weight_mem [WSTORE_DEPTH];
    logic signed [31:0] bias_mem [MAX_KERNELS];
    int unsigned        regs [6];
    int unsigned        col_pos, row_pos;

    t_res   pending_q[$];
    int     n_errors;
    int     n_requests;
    int     n_results;
    longint cycles = 0;
    bit     quiet_tx, quiet_rx, hold_req;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t with %0d results outstanding", $time, pending_q.size());
            $display("conv2d_bias_relu_top: mismatch");
            $finish;
        end
    end

    function automatic logic signed [15:0] clip16(input logic signed [31:0] v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic int unsigned limit_reg(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Advance the mirror by one request and queue the results it causes
    task automatic conv_predict(input t_req q);
        int unsigned w, h, kw, kh, kc, r, c, orow, ocol;
        longint acc;
        logic signed [15:0] win [WIN_N];
        t_res e;
        if (q.kind == KIND_WEIGHT) begin
            if (q.slot < WSTORE_DEPTH) weight_mem[q.slot] = clip16(q.sample);
        end else if (q.kind == KIND_BIAS) begin
            if (q.slot < MAX_KERNELS) bias_mem[q.slot] = q.sample;
        end else if (q.kind == KIND_PIXEL) begin
            w  = limit_reg(regs[CFG_IMAGE_WIDTH], MAX_WIDTH);
            h  = limit_reg(regs[CFG_IMAGE_HEIGHT], MAX_HEIGHT);
            kw = limit_reg(regs[CFG_KERNEL_WIDTH], MAX_KSIZE);
            kh = limit_reg(regs[CFG_KERNEL_HEIGHT], MAX_KSIZE);
            kc = limit_reg(regs[CFG_KERNEL_COUNT], MAX_KERNELS);
            if (q.frame_start) begin
                col_pos = 0;
                row_pos = 0;
            end
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) row_pos = 0;
            r = row_pos;
            c = col_pos;
            line_mem[(r % MAX_KSIZE) * MAX_WIDTH + c] = clip16(q.sample);
            if (r + 1 >= kh && c + 1 >= kw) begin
                orow = r + 1 - kh;
                ocol = c + 1 - kw;
                for (int y = 0; y < kh; y++)
                    for (int x = 0; x < kw; x++)
                        win[y * MAX_KSIZE + x] =
                            line_mem[((orow + y) % MAX_KSIZE) * MAX_WIDTH + ocol + x];
                for (int k = 0; k < kc; k++) begin
                    acc = 0;
                    for (int y = 0; y < kh; y++)
                        for (int x = 0; x < kw; x++)
                            acc += longint'(win[y * MAX_KSIZE + x]) *
                                   longint'(weight_mem[k * WIN_N + y * MAX_KSIZE + x]);
                    if (regs[CFG_BIAS_ENABLE] != 0) acc += longint'(bias_mem[k]);
                    e.kidx = KIDX_W'(k);
                    e.row  = ROW_W'(orow);
                    e.col  = COL_W'(ocol);
                    e.act  = (acc < 0) ? 32'd0 :
                             (acc > 64'sd4294967295) ? 32'hFFFF_FFFF : acc[31:0];
                    e.last = (k + 1 == kc);
                    pending_q.push_back(e);
                end
                // Typed rows carry their activation by hand
                if (q.typed) pending_q[$].act = q.typed_act;
            end
            col_pos = c + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= h) row_pos = 0;
            end
        end
    endtask

    // Offer one request, keeping valid high across back-to-back requests
    task automatic issue_req(input t_req q);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.kind        <= q.kind;
        pix_if.frame_start <= q.frame_start;
        pix_if.slot        <= q.slot;
        pix_if.sample      <= q.sample;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        conv_predict(q);
        n_requests++;
    endtask

    // Write all six registers in one burst; the block must be idle
    task automatic write_regs(input int unsigned v [6]);
        pix_if.valid <= 1'b0;
        for (int i = 0; i < 6; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= t_cfg_idx'(i);
            cfg_if.data  <= CFG_DATA_W'(v[i]);
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
            regs[i] = v[i];
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Wait for every expected result, then let the block settle
    task automatic drain();
        pix_if.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 16383)) - 8192;
        endcase
    endfunction

    function automatic t_req mk_req(input logic [1:0] kind, input logic fs,
                                    input logic [7:0] slot, input logic signed [31:0] s);
        t_req q;
        q.kind = kind;
        q.frame_start = fs;
        q.slot = slot;
        q.sample = s;
        q.typed = 1'b0;
        q.typed_act = '0;
        return q;
    endfunction

    // Result sink: random stalls, one long hold on request
    initial begin
        int stall;
        t_res e;
        bit held;
        held = 1'b0;
        res_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !held) begin
                res_if.ready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++) @(posedge i_clk);
                held = 1'b1;
            end else begin
                stall = quiet_rx ? 0 : $urandom_range(0, MAX_GAP);
                if (stall > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            n_results++;
            if (pending_q.size() == 0) begin
                $display("%0t unexpected result k=%0d row=%0d col=%0d act=%h", $time,
                         res_if.kernel_index, res_if.out_row, res_if.out_col,
                         res_if.activation);
                n_errors++;
            end else begin
                e = pending_q.pop_front();
                if (res_if.kernel_index !== e.kidx || res_if.out_row !== e.row ||
                    res_if.out_col !== e.col || res_if.activation !== e.act ||
                    res_if.last !== e.last) begin
                    $display("%0t result differs: expected k=%0d row=%0d col=%0d act=%h last=%0d",
                             $time, e.kidx, e.row, e.col, e.act, e.last);
                    $display("%0t                   actual k=%0d row=%0d col=%0d act=%h last=%0d",
                             $time, res_if.kernel_index, res_if.out_row, res_if.out_col,
                             res_if.activation, res_if.last);
                    n_errors++;
                end
            end
        end
    end

    // Directed table: 4x3 image, one 1x1 kernel with bias
    t_req dir_tab [16];
    // Random phases: width, height, kernel width, kernel height, count, bias, requests
    int unsigned phase_tab [8][7] = '{
        '{4,   4,    3, 3, 8,  1, 24},
        '{64,  2,    5, 1, 3,  0, 8},
        '{1,   20,   1, 5, 2,  1, 8},
        '{3,   3,    3, 3, 8,  1, 10},
        '{3,   2,    4, 3, 4,  1, 4},
        '{0,   0,    0, 0, 0,  0, 4},
        '{127, 2047, 7, 1, 15, 1, 8},
        '{3,   9,    1, 7, 9,  1, 16}
    };

    initial begin
        int unsigned v [6];
        t_req q;
        int r;
        bit first;
        pix_if.valid = 1'b0;
        pix_if.kind = KIND_PIXEL;
        pix_if.frame_start = 1'b0;
        pix_if.slot = '0;
        pix_if.sample = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_IMAGE_WIDTH;
        cfg_if.data = '0;
        n_errors = 0;
        n_requests = 0;
        n_results = 0;
        hold_req = 1'b0;
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        regs = '{64, 64, 3, 3, 8, 1};
        col_pos = 0;
        row_pos = 0;
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (weight_mem[i]) weight_mem[i] = '0;
        foreach (bias_mem[i]) bias_mem[i] = '0;

        dir_tab[0]  = mk_req(KIND_WEIGHT, 1'b0, 8'd0,   32'sh0000_1000);
        dir_tab[1]  = mk_req(KIND_BIAS,   1'b0, 8'd0,   32'sh0);
        dir_tab[2]  = mk_req(KIND_WEIGHT, 1'b0, 8'd200, 32'sd123);
        dir_tab[3]  = mk_req(KIND_BIAS,   1'b0, 8'd255, 32'sd5);
        dir_tab[4]  = mk_req(KIND_UNUSED, 1'b1, 8'd0,   32'sh7FFF_FFFF);
        dir_tab[5]  = mk_req(KIND_PIXEL,  1'b1, 8'd0,   32'sd32767);
        dir_tab[6]  = mk_req(KIND_PIXEL,  1'b0, 8'd0,   32'sh7FFF_FFFF);
        dir_tab[7]  = mk_req(KIND_PIXEL,  1'b0, 8'd0,   -32'sd32768);
        dir_tab[8]  = mk_req(KIND_PIXEL,  1'b0, 8'd0,   32'sh8000_0000);
        dir_tab[9]  = mk_req(KIND_WEIGHT, 1'b1, 8'd0,   32'sh7FFF_FFFF);
        dir_tab[10] = mk_req(KIND_BIAS,   1'b1, 8'd0,   32'sh7FFF_FFFF);
        dir_tab[11] = mk_req(KIND_PIXEL,  1'b0, 8'd0,   32'sd32767);
        dir_tab[12] = mk_req(KIND_PIXEL,  1'b0, 8'd0,   32'sd1);
        dir_tab[13] = mk_req(KIND_BIAS,   1'b0, 8'd0,   32'sh8000_0000);
        dir_tab[14] = mk_req(KIND_PIXEL,  1'b0, 8'd0,   32'sd1);
        dir_tab[15] = mk_req(KIND_PIXEL,  1'b1, 8'd0,   32'sd0);
        // Activations readable at a glance: unit weight, then full-scale weight and bias
        dir_tab[5].typed = 1'b1;   dir_tab[5].typed_act  = 32'h07FF_F000;
        dir_tab[6].typed = 1'b1;   dir_tab[6].typed_act  = 32'h07FF_F000;
        dir_tab[7].typed = 1'b1;   dir_tab[7].typed_act  = 32'h0;
        dir_tab[8].typed = 1'b1;   dir_tab[8].typed_act  = 32'h0;
        dir_tab[11].typed = 1'b1;  dir_tab[11].typed_act = 32'hBFFF_0000;
        dir_tab[12].typed = 1'b1;  dir_tab[12].typed_act = 32'h8000_7FFE;
        dir_tab[14].typed = 1'b1;  dir_tab[14].typed_act = 32'h0;
        dir_tab[15].typed = 1'b1;  dir_tab[15].typed_act = 32'h0;

        // Hold reset at the start, then release it
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every weight and bias so no unwritten entry is ever read
        for (int i = 0; i < WSTORE_DEPTH; i++)
            issue_req(mk_req(KIND_WEIGHT, 1'b0, 8'(i), rand_sample()));
        for (int i = 0; i < MAX_KERNELS; i++)
            issue_req(mk_req(KIND_BIAS, 1'b0, 8'(i), rand_sample()));
        drain();

        v = '{4, 3, 1, 1, 1, 1};
        write_regs(v);
        foreach (dir_tab[i]) issue_req(dir_tab[i]);
        drain();

        // Random phases over several register settings
        foreach (phase_tab[p]) begin
            for (int i = 0; i < 6; i++) v[i] = phase_tab[p][i];
            write_regs(v);
            quiet_tx = (p == 3);
            quiet_rx = (p == 3) || (p == 6);
            if (p == 0) hold_req = 1'b1;
            first = 1'b1;
            for (int n = 0; n < phase_tab[p][6]; n++) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    q = mk_req(KIND_WEIGHT, 1'($urandom_range(0, 1)),
                               8'($urandom_range(0, WSTORE_DEPTH - 1)), rand_sample());
                end else if (r < 9) begin
                    q = mk_req(KIND_BIAS, 1'($urandom_range(0, 1)),
                               8'($urandom_range(0, MAX_KERNELS - 1)), rand_sample());
                end else if (r < 12) begin
                    // Noise: unused kind or out-of-range slot
                    q = mk_req($urandom_range(0, 1) ? KIND_UNUSED :
                               ($urandom_range(0, 1) ? KIND_WEIGHT : KIND_BIAS),
                               1'($urandom_range(0, 1)), 8'($urandom_range(200, 255)),
                               $urandom);
                end else begin
                    q = mk_req(KIND_PIXEL, first || ($urandom_range(0, 49) == 0),
                               8'($urandom), rand_sample());
                    first = 1'b0;
                end
                issue_req(q);
            end
            drain();
        end

        $display("ran %0d requests over %0d register settings, checked %0d results",
                 n_requests, $size(phase_tab) + 1, n_results);
        $display("covered saturation, ReLU clamp, oversized kernels and register clamping");
        if (n_errors == 0) begin
            $display("conv2d_bias_relu_top: match");
        end else begin
            $display("conv2d_bias_relu_top: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
